>>> rtl/jnec_pkg.sv
package jnec_pkg;

	localparam int          CHAR_W       = 16;
	localparam int          NUM_SLOTS    = 3;
	localparam int          NUM_CODES    = 10;
	localparam int          QUEUE_DEPTH  = 2;
	localparam logic [15:0] BS_CHAR      = 16'h005c;
	localparam logic [15:0] HEX_NUM_BASE = 16'h0030;
	localparam logic [15:0] HEX_LTR_BASE = 16'h0057;

	// characters that have an escape sequence, backslash first
	localparam logic [15:0] CODE_CHARS [NUM_CODES] = '{
		16'h005c, 16'h0020, 16'h0022, 16'h0026, 16'h0027,
		16'h002f, 16'h003a, 16'h003c, 16'h003e, 16'h0040
	};

	// up to three decided characters of an item; exp asks for backslash plus two hex digits
	typedef struct packed {
		logic [NUM_SLOTS-1:0]             slot_v;
		logic [NUM_SLOTS-1:0]             slot_exp;
		logic [NUM_SLOTS-1:0][CHAR_W-1:0] slot_char;
		logic                             last;
	} entry_t;

	typedef struct packed {
		logic              hit;
		logic [CHAR_W-1:0] ch;
	} code_match_t;

	// lowercase hex digit of a nibble
	function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
		logic [CHAR_W-1:0] r;
		if (nib < 4'd10) begin
			r = HEX_NUM_BASE + {12'd0, nib};
		end else begin
			r = HEX_LTR_BASE + {12'd0, nib};
		end
		return r;
	endfunction

	// special character other than backslash
	function automatic logic is_special(input logic [CHAR_W-1:0] c);
		logic r;
		r = 1'b0;
		for (int k = 1; k < NUM_CODES; k++) begin
			if (c == CODE_CHARS[k]) begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

	// two hex digits that name one of the codes
	function automatic code_match_t match_pair(input logic [CHAR_W-1:0] a,
			input logic [CHAR_W-1:0] b);
		code_match_t r;
		r = '0;
		for (int k = 0; k < NUM_CODES; k++) begin
			if (!r.hit && a == hex_digit(CODE_CHARS[k][7:4]) &&
					b == hex_digit(CODE_CHARS[k][3:0])) begin
				r.hit = 1'b1;
				r.ch  = CODE_CHARS[k];
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/jnec_front.sv
module jnec_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [jnec_pkg::CHAR_W-1:0]   in_char,
	input  logic                          in_last,
	input  logic                          direction,
	input  logic                          q_full,
	output logic                          push,
	output jnec_pkg::entry_t              push_entry
);
	import jnec_pkg::*;

	logic [CHAR_W-1:0] win_q [2];
	logic [1:0]        win_cnt_q;
	logic [CHAR_W-1:0] seq [NUM_SLOTS];
	logic [1:0]        n;
	logic              stop;
	logic [1:0]        skip;
	logic [1:0]        keep;
	logic [1:0]        win_cnt_d;
	logic [CHAR_W-1:0] win_d [2];
	entry_t            ent;
	code_match_t       mt;
	logic              accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// window plus the new character
	always_comb begin
		seq[0] = in_char;
		seq[1] = in_char;
		seq[2] = in_char;
		n      = 2'd1;
		case (win_cnt_q)
			2'd1: begin
				seq[0] = win_q[0];
				n      = 2'd2;
			end
			2'd2: begin
				seq[0] = win_q[0];
				seq[1] = win_q[1];
				n      = 2'd3;
			end
			default: begin
				n = 2'd1;
			end
		endcase
	end

	// decide each position of the sequence
	always_comb begin
		ent      = '0;
		ent.last = in_last;
		stop     = 1'b0;
		skip     = 2'd0;
		keep     = 2'd0;
		mt       = match_pair(seq[1], seq[2]);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (2'(i) < n && !stop) begin
				if (skip != 2'd0) begin
					skip = skip - 2'd1;
				end else if (seq[i] == BS_CHAR) begin
					if (i == 0 && n == 2'd3) begin
						ent.slot_v[i] = 1'b1;
						if (!direction) begin
							ent.slot_char[i] = BS_CHAR;
							ent.slot_exp[i]  = mt.hit;
						end else if (mt.hit) begin
							ent.slot_char[i] = mt.ch;
							skip             = 2'd2;
						end else begin
							ent.slot_char[i] = BS_CHAR;
						end
					end else if (in_last) begin
						ent.slot_v[i]    = 1'b1;
						ent.slot_char[i] = BS_CHAR;
					end else begin
						stop = 1'b1;
						keep = 2'(i);
					end
				end else begin
					ent.slot_v[i]    = 1'b1;
					ent.slot_char[i] = seq[i];
					ent.slot_exp[i]  = !direction && is_special(seq[i]);
				end
			end
		end
	end

	// undecided tail goes back into the window
	always_comb begin
		win_cnt_d = 2'd0;
		win_d[0]  = seq[0];
		win_d[1]  = seq[1];
		if (stop) begin
			win_cnt_d = n - keep;
			case (keep)
				2'd1: begin
					win_d[0] = seq[1];
					win_d[1] = seq[2];
				end
				2'd2: begin
					win_d[0] = seq[2];
				end
				default: begin
					win_d[0] = seq[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= 2'd0;
		end else if (accept) begin
			win_cnt_q <= win_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= win_d[0];
			win_q[1] <= win_d[1];
		end
	end

	assign push       = accept && (ent.slot_v != '0);
	assign push_entry = ent;

	a_win_head_bs: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt_q != 2'd0 |-> win_q[0] == BS_CHAR)
		else $error("window does not start with a backslash");

	a_win_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt_q != 2'd3)
		else $error("window holds more than two characters");

endmodule

>>> rtl/jnec_queue.sv
module jnec_queue #(
	parameter int QDEPTH = jnec_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jnec_pkg::entry_t push_entry,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output jnec_pkg::entry_t head
);
	import jnec_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	entry_t        mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("item popped from an empty queue");

endmodule

>>> rtl/jnec_back.sv
module jnec_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  jnec_pkg::entry_t            head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [jnec_pkg::CHAR_W-1:0] out_char,
	output logic                        run_end,
	output logic                        string_end
);
	import jnec_pkg::*;

	logic [NUM_SLOTS-1:0] done_q;
	logic [1:0]           sub_q;
	logic [NUM_SLOTS-1:0] remaining;
	logic [NUM_SLOTS-1:0] cur_oh;
	logic [1:0]           cur;
	logic [CHAR_W-1:0]    cur_char;
	logic                 cur_exp;
	logic [CHAR_W-1:0]    gen_char;
	logic                 slot_finish;
	logic                 entry_finish;
	logic                 gen_valid;
	logic                 load;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 run_end_q;
	logic                 string_end_q;

	assign remaining = head.slot_v & ~done_q;
	assign gen_valid = !empty;

	// lowest slot still to be sent
	always_comb begin
		if (remaining[0]) begin
			cur = 2'd0;
		end else if (remaining[1]) begin
			cur = 2'd1;
		end else begin
			cur = 2'd2;
		end
		cur_oh   = NUM_SLOTS'(1) << cur;
		cur_char = head.slot_char[cur];
		cur_exp  = head.slot_exp[cur];
	end

	// one output character of the current slot
	always_comb begin
		case (sub_q)
			2'd1:    gen_char = hex_digit(cur_char[7:4]);
			2'd2:    gen_char = hex_digit(cur_char[3:0]);
			default: gen_char = cur_exp ? BS_CHAR : cur_char;
		endcase
		slot_finish  = !cur_exp || sub_q == 2'd2;
		entry_finish = (remaining & ~cur_oh) == '0;
	end

	assign load = gen_valid && (!out_valid_q || out_ready);
	assign pop  = load && slot_finish && entry_finish;

	// expansion progress within the head item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			sub_q  <= 2'd0;
		end else if (load) begin
			if (slot_finish) begin
				sub_q  <= 2'd0;
				done_q <= entry_finish ? '0 : (done_q | cur_oh);
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q   <= gen_char;
			run_end_q    <= slot_finish && entry_finish;
			string_end_q <= slot_finish && entry_finish && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		gen_valid |-> remaining != '0)
		else $error("queued item has no slot left to send");

	a_sub_on_expand: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd0 |-> (gen_valid && cur_exp && sub_q != 2'd3))
		else $error("hex digit step outside an escaped slot");

endmodule

>>> rtl/jid_node_escape_codec_core.sv
// channel  | signals                                             | role
// ---------+-----------------------------------------------------+---------------------
// in       | in_valid, in_ready, in_char, in_last                | node string chars
// out      | out_valid, out_ready, out_char, run_end, string_end | converted string
// cfg      | cfg_valid, cfg_ready, cfg_data                      | 0 escape, 1 unescape
//
// the front takes one item per cycle while the queue has room; the back sends one
// output character per cycle while the queue is not empty and out_ready allows; a plain
// or decoded character gives one output character, an escaped one three; the back's output port sets the rate
// an item that only fills the lookahead window is taken by the front with no output
// arst_n clears the window count, queue, output valid and sets direction to escape;
// cfg is always ready
// a stalled out_ready holds the output register and then fills the queue, then in_ready drops
module jid_node_escape_codec_core #(
	parameter int QDEPTH = jnec_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [jnec_pkg::CHAR_W-1:0] in_char,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [jnec_pkg::CHAR_W-1:0] out_char,
	output logic                        run_end,
	output logic                        string_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data
);
	import jnec_pkg::*;

	logic   direction_q;
	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;

	// direction register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			direction_q <= cfg_data;
		end
	end

	jnec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.in_last    (in_last),
		.direction  (direction_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	jnec_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.empty      (q_empty),
		.pop        (pop),
		.head       (head)
	);

	jnec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
